/* design/pwg_pkg.sv */
`default_nettype none
package pwg_pkg;

	typedef enum logic [1:0] {
		WAVE_SQUARE   = 2'd0,
		WAVE_SAW      = 2'd1,
		WAVE_TRIANGLE = 2'd2,
		WAVE_SINE     = 2'd3
	} wave_t;

	typedef enum logic [1:0] {
		REG_WAVEFORM  = 2'd0,
		REG_FS_HZ     = 2'd1,
		REG_TONE_FREQ = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PER,
		ST_SMP,
		ST_IDX,
		ST_ROM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic per_start;
		logic smp_start;
		logic per_load;
		logic smp_load;
		logic idx_load;
		logic rom_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sts_t;

	localparam logic [7:0] SAMPLE_MAX = 8'hFF;
	localparam logic [7:0] SAMPLE_MID = 8'h7F;
	localparam logic [17:0] RESET_FS_HZ = 18'd8000;
	localparam logic [15:0] RESET_TONE_FREQ = 16'd440;

	function automatic logic [7:0] sine_entry(input logic [63:0] z);
		logic [63:0] z2;
		logic [63:0] r;
		logic [63:0] s;
		z2 = (z * z) >> 16;
		r = 64'd11;
		r = 64'd307 - ((z2 * r) >> 16);
		r = 64'd5223 - ((z2 * r) >> 16);
		r = 64'd42334 - ((z2 * r) >> 16);
		r = 64'd102944 - ((z2 * r) >> 16);
		s = (z * r) >> 16;
		s = (64'd255 * s + 64'd32768) >> 16;
		return (s > 64'd255) ? 8'd255 : s[7:0];
	endfunction

	function automatic logic [7:0] sine_level(input logic [7:0] e, input logic upper);
		logic [15:0] m;
		m = 16'd127 * {8'd0, e};
		if (upper) begin
			return SAMPLE_MID + 8'(m / 16'd255);
		end
		return SAMPLE_MID - 8'((m + 16'd254) / 16'd255);
	endfunction

endpackage
`default_nettype wire

/* design/pwg_div.sv */
`default_nettype none
module pwg_div #(
	parameter int NW = 31,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quot
);
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   diff;

	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign diff = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= CW'(NW - 1);
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			rem_q <= diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ~diff[DW]};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

/* design/pwg_ctrl.sv */
`default_nettype none
module pwg_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr,
	input  wire pwg_pkg::wave_t  waveform,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire pwg_pkg::sts_t   sts,
	output pwg_pkg::cmd_t        cmd
);
	pwg_pkg::state_t state_q;
	pwg_pkg::state_t state_d;
	logic            pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwg_pkg::ST_IDLE;
			pend_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			pend_q  <= cfg_wr | (pend_q & ~cmd.per_start);
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			pwg_pkg::ST_IDLE: begin
				in_ready = ~pend_q & ~cfg_wr;
				if (pend_q && !cfg_wr) begin
					cmd.per_start = 1'b1;
					state_d = pwg_pkg::ST_PER;
				end else if (in_valid && in_ready) begin
					cmd.accept = 1'b1;
					state_d = (waveform == pwg_pkg::WAVE_SQUARE) ?
						pwg_pkg::ST_OUT : pwg_pkg::ST_LOAD;
				end
			end
			pwg_pkg::ST_LOAD: begin
				cmd.smp_start = 1'b1;
				state_d = pwg_pkg::ST_SMP;
			end
			pwg_pkg::ST_PER: begin
				if (sts.div_done) begin
					cmd.per_load = 1'b1;
					state_d = pwg_pkg::ST_IDLE;
				end
			end
			pwg_pkg::ST_SMP: begin
				if (sts.div_done) begin
					if (waveform == pwg_pkg::WAVE_SINE) begin
						state_d = pwg_pkg::ST_IDX;
					end else begin
						cmd.smp_load = 1'b1;
						state_d = pwg_pkg::ST_OUT;
					end
				end
			end
			pwg_pkg::ST_IDX: begin
				cmd.idx_load = 1'b1;
				state_d = pwg_pkg::ST_ROM;
			end
			pwg_pkg::ST_ROM: begin
				cmd.rom_load = 1'b1;
				state_d = pwg_pkg::ST_OUT;
			end
			pwg_pkg::ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = pwg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pwg_pkg::ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

/* design/pwg_datapath.sv */
`default_nettype none
module pwg_datapath #(
	parameter int MAX_PERIOD = 16384,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pwg_pkg::cmd_t  cmd,
	output pwg_pkg::sts_t       sts,
	input  wire pwg_pkg::wave_t waveform,
	input  wire logic [17:0]    fs_hz,
	input  wire logic [15:0]    tone_freq,
	input  wire logic           restart,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_sample,
	output logic                out_end,
	output logic                out_clipped
);
	localparam int PW = $clog2(MAX_PERIOD + 1);
	localparam int DW = (PW > 16) ? PW : 16;
	localparam int NW = PW + 16;
	localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

	logic [PW-1:0]   period_q;
	logic            clip_q;
	logic [PW-1:0]   phase_q;
	logic [PW-1:0]   t_q;
	logic            end_q;
	logic [7:0]      res_q;
	logic [IW-1:0]   idx_q;
	logic            upper_q;
	logic            valid_q;
	logic [7:0]      sample_q;
	logic            oend_q;
	logic            oclip_q;

	logic [PW-1:0]   half;
	logic [PW-1:0]   quarter;
	logic [PW+1:0]   three_n;
	logic [PW-1:0]   tq;
	logic [PW-1:0]   adj;
	logic [PW-1:0]   t_in;
	logic            end_in;
	logic [NW-1:0]   adj255;
	logic [NW-1:0]   h510;
	logic [NW-1:0]   div_num;
	logic [DW-1:0]   div_den;
	logic            div_done;
	logic [NW-1:0]   quot;
	logic [7:0]      quot_sat;
	logic [14:0]     fm;
	logic [15+IW-1:0] prod;
	logic [PW-1:0]   period_d;
	logic            clip_d;
	logic [7:0]      sine_hi [SINE_TABLE_DEPTH+1];
	logic [7:0]      sine_lo [SINE_TABLE_DEPTH+1];

	for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_sine
		localparam logic [63:0] Z = (64'(gi) << 16) / SINE_TABLE_DEPTH;
		localparam logic [7:0] E = (gi == SINE_TABLE_DEPTH) ?
			8'd255 : pwg_pkg::sine_entry(Z);
		assign sine_hi[gi] = pwg_pkg::sine_level(E, 1'b1);
		assign sine_lo[gi] = pwg_pkg::sine_level(E, 1'b0);
	end

	assign half = period_q >> 1;
	assign quarter = period_q >> 2;
	assign three_n = (PW+2)'(period_q) + {1'b0, period_q, 1'b0};
	assign tq = three_n[PW+1:2];
	assign adj = (t_q < tq) ? t_q + quarter : t_q - tq;
	assign adj255 = NW'({adj, 8'd0}) - NW'(adj);
	assign h510 = NW'({half, 9'd0}) - NW'({half, 1'b0});

	assign t_in = (restart || phase_q >= period_q) ? '0 : phase_q;
	assign end_in = (t_in == period_q - 1'b1);

	always_comb begin
		div_num = '0;
		div_den = DW'(period_q);
		if (cmd.per_start) begin
			div_num = NW'(fs_hz);
			div_den = DW'(tone_freq);
		end else begin
			case (waveform)
				pwg_pkg::WAVE_TRIANGLE: begin
					div_den = DW'(half);
					if (adj <= half) begin
						div_num = adj255;
					end else begin
						div_num = (h510 > adj255) ? h510 - adj255 : '0;
					end
				end
				pwg_pkg::WAVE_SINE: begin
					div_num = {t_q, 16'd0};
				end
				default: begin
					div_num = adj255;
				end
			endcase
		end
	end

	pwg_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.per_start | cmd.smp_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quot(quot)
	);

	assign quot_sat = (quot > NW'(pwg_pkg::SAMPLE_MAX)) ? pwg_pkg::SAMPLE_MAX : quot[7:0];

	always_comb begin
		clip_d = 1'b0;
		period_d = quot[PW-1:0];
		if (tone_freq == '0 || quot > NW'(MAX_PERIOD)) begin
			clip_d = 1'b1;
			period_d = PW'(MAX_PERIOD);
		end else if (quot < NW'(2)) begin
			clip_d = 1'b1;
			period_d = PW'(2);
		end
	end

	assign fm = quot[14] ? 15'd16384 - {1'b0, quot[13:0]} : {1'b0, quot[13:0]};
	assign prod = (15+IW)'(fm) * (15+IW)'(SINE_TABLE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				phase_q <= end_in ? '0 : t_in + 1'b1;
			end
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.per_load) begin
			period_q <= period_d;
			clip_q   <= clip_d;
		end
		if (cmd.accept) begin
			t_q   <= t_in;
			end_q <= end_in;
		end
		if (cmd.smp_load) begin
			res_q <= quot_sat;
		end
		if (cmd.idx_load) begin
			idx_q   <= prod[14 +: IW];
			upper_q <= ~quot[15];
		end
		if (cmd.rom_load) begin
			res_q <= upper_q ? sine_hi[idx_q] : sine_lo[idx_q];
		end
		if (cmd.out_load) begin
			sample_q <= (waveform == pwg_pkg::WAVE_SQUARE) ?
				((t_q < half) ? pwg_pkg::SAMPLE_MAX : 8'd0) : res_q;
			oend_q   <= end_q;
			oclip_q  <= clip_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_free = ~valid_q | out_ready;
	assign out_valid = valid_q;
	assign out_sample = sample_q;
	assign out_end = oend_q;
	assign out_clipped = oclip_q;
endmodule
`default_nettype wire

/* design/periodic_waveform_generator.sv */
`default_nettype none
// Tone generator: each beat on the input stream (restart in bit 0 of s_axis_tdata) yields one
// 8-bit unsigned sample on the output stream, with tlast marking the last sample of a period and
// tuser flagging a period clipped to 2..MAX_PERIOD. Period = fs_hz / tone_freq, computed
// by a shared restoring divider that produces one quotient bit per clock, on a numerator of
// $clog2(MAX_PERIOD+1)+16 bits (31 by default). A square sample passes from accept through
// ST_OUT to the output register; saw and triangle go through ST_LOAD, ST_SMP and ST_OUT, and
// sine through ST_LOAD, ST_SMP, ST_IDX, ST_ROM and ST_OUT. Each register write, and reset,
// triggers a period recompute during which no input beat is taken. One beat is worked on at
// a time; the output register lets the next beat in while a finished sample waits.
module periodic_waveform_generator #(
	parameter int MAX_PERIOD = 16384,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [0] restart, [7:1] zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] sample
	output logic             m_axis_tlast,
	output logic [0:0]       m_axis_tuser   // [0] period_clipped
);
	pwg_pkg::wave_t    waveform_q;
	logic [17:0]       fs_hz_q;
	logic [15:0]       tone_freq_q;
	logic              cfg_wr;
	pwg_pkg::reg_idx_t reg_idx;
	pwg_pkg::cmd_t     cmd;
	pwg_pkg::sts_t     sts;
	logic              out_clipped;

	assign pready = 1'b1;
	assign reg_idx = pwg_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel & penable & pwrite & pready & (reg_idx != pwg_pkg::REG_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q  <= pwg_pkg::WAVE_SQUARE;
			fs_hz_q     <= pwg_pkg::RESET_FS_HZ;
			tone_freq_q <= pwg_pkg::RESET_TONE_FREQ;
		end else if (cfg_wr) begin
			case (reg_idx)
				pwg_pkg::REG_WAVEFORM:  waveform_q <= pwg_pkg::wave_t'(pwdata[1:0]);
				pwg_pkg::REG_FS_HZ:     fs_hz_q <= pwdata[17:0];
				pwg_pkg::REG_TONE_FREQ: tone_freq_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pwg_pkg::REG_WAVEFORM:  prdata = {30'd0, waveform_q};
			pwg_pkg::REG_FS_HZ:     prdata = {14'd0, fs_hz_q};
			pwg_pkg::REG_TONE_FREQ: prdata = {16'd0, tone_freq_q};
			default:                prdata = '0;
		endcase
	end

	pwg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_wr),
		.waveform(waveform_q),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts(sts),
		.cmd(cmd)
	);

	pwg_datapath #(
		.MAX_PERIOD(MAX_PERIOD),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.waveform(waveform_q),
		.fs_hz(fs_hz_q),
		.tone_freq(tone_freq_q),
		.restart(s_axis_tdata[0]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_sample(m_axis_tdata),
		.out_end(m_axis_tlast),
		.out_clipped(out_clipped)
	);

	assign m_axis_tuser = out_clipped;

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !s_axis_tready)
		else $error("input beat taken while another is in flight");

	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !s_axis_tready)
		else $error("input beat taken before period recompute");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output beat overwritten while stalled");

	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.per_start && cmd.smp_start))
		else $error("divider started twice");
endmodule
`default_nettype wire
